// File: src/spum_pkg.sv
package spum_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DEPTH_W   = 5;

  // top value reported when the stack holds nothing
  localparam logic signed [WORD_W-1:0] EMPTY_TOP = -32'sd1000;

  // operation codes
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic                     kind;
    logic signed [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    logic                     is_empty;
    logic [1:0]               status;
  } out_t;

endpackage

// File: src/stack_pop_until_match.sv
// bounded lifo of signed 32-bit words. each input beat is a push (kind 0) or a
// remove-until (kind 1) that pops entries until the top equals value or the
// stack runs empty; every input beat returns exactly one output beat carrying
// the new top (-1000 when empty), depth, an empty flag and a status (ok, push
// dropped because full, value not found so stack emptied). pushes can follow
// back to back while the output register takes each result. a remove-until
// that pops nothing needs no memory read; any other pops the top and, if
// entries remain, walks down the stack comparing each entry with value until
// one matches or the stack runs empty. the entries below the top come out
// of the memory one registered read per cycle. the top entry is kept in a
// register, so a match on top or a full push needs no memory access. the
// output register lets the next beat be taken while a finished result still
// waits on out_ready. no clearing pass after reset: entries are only read
// below the fill count.
module stack_pop_until_match #(
  parameter int unsigned DEPTH = spum_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  spum_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output spum_pkg::out_t  out_data
);

  localparam int unsigned AW = $clog2(DEPTH);

  // result handoff from the sequencer to the output register
  logic           res_valid;
  logic           res_take;
  spum_pkg::out_t res;

  // storage port
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [spum_pkg::WORD_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [spum_pkg::WORD_W-1:0] mem_rdata;

  // sequencer: push writes, remove-until walks down one entry per cycle
  spum_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // stack entries, registered read
  spum_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register decouples result delivery from intake
  spum_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: src/spum_mem.sv
module spum_mem #(
  parameter int unsigned DEPTH = spum_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(DEPTH)-1:0]           waddr,
  input  logic [spum_pkg::WORD_W-1:0]        wdata,
  input  logic                               re,
  input  logic [$clog2(DEPTH)-1:0]           raddr,
  output logic [spum_pkg::WORD_W-1:0]        rdata
);

  logic [spum_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/spum_obuf.sv
module spum_obuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_valid,
  input  spum_pkg::out_t  res,
  output logic            res_take,
  output logic            out_valid,
  input  logic            out_ready,
  output spum_pkg::out_t  out_data
);

  // slot is free when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

endmodule

// File: src/spum_ctrl.sv
module spum_ctrl #(
  parameter int unsigned DEPTH = spum_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  spum_pkg::in_t                      in_data,
  output logic                               res_valid,
  output spum_pkg::out_t                     res,
  input  logic                               res_take,
  output logic                               mem_we,
  output logic [$clog2(DEPTH)-1:0]           mem_waddr,
  output logic [spum_pkg::WORD_W-1:0]        mem_wdata,
  output logic                               mem_re,
  output logic [$clog2(DEPTH)-1:0]           mem_raddr,
  input  logic [spum_pkg::WORD_W-1:0]        mem_rdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                        state, state_next;
  logic [CW-1:0]                     count, count_next;
  logic signed [spum_pkg::WORD_W-1:0] top, top_next;
  logic signed [spum_pkg::WORD_W-1:0] key, key_next;
  spum_pkg::out_t                    res_next;
  logic                              acc;
  logic [CW-1:0]                     count_dec;
  logic [CW-1:0]                     count_inc;
  logic [CW-1:0]                     count_dec2;

  assign in_ready  = (state == S_IDLE) || ((state == S_HOLD) && res_take);
  assign acc       = in_valid && in_ready;
  assign res_valid = (state == S_HOLD);

  assign count_inc  = count + CW'(1);
  assign count_dec  = count - CW'(1);
  assign count_dec2 = count - CW'(2);

  always_comb begin
    state_next = state;
    count_next = count;
    top_next   = top;
    key_next   = key;
    res_next   = res;
    mem_we     = 1'b0;
    mem_waddr  = count[AW-1:0];
    mem_wdata  = in_data.value;
    mem_re     = 1'b0;
    mem_raddr  = count_dec2[AW-1:0];

    if (state == S_HOLD && res_take) begin
      state_next = S_IDLE;
    end

    if (acc) begin
      state_next = S_HOLD;
      key_next   = in_data.value;
      priority if (in_data.kind == spum_pkg::KIND_PUSH) begin
        if (count < CW'(DEPTH)) begin
          mem_we     = 1'b1;
          count_next = count_inc;
          top_next   = in_data.value;
          res_next   = '{in_data.value, spum_pkg::DEPTH_W'(count_inc), 1'b0,
                         spum_pkg::ST_OK};
        end else begin
          res_next = '{top, spum_pkg::DEPTH_W'(count), 1'b0, spum_pkg::ST_FULL};
        end
      end else if (count == CW'(0)) begin
        res_next = '{spum_pkg::EMPTY_TOP, spum_pkg::DEPTH_W'(0), 1'b1,
                     spum_pkg::ST_NOT_FOUND};
      end else if (top == in_data.value) begin
        res_next = '{top, spum_pkg::DEPTH_W'(count), 1'b0, spum_pkg::ST_OK};
      end else if (count == CW'(1)) begin
        count_next = '0;
        res_next   = '{spum_pkg::EMPTY_TOP, spum_pkg::DEPTH_W'(0), 1'b1,
                       spum_pkg::ST_NOT_FOUND};
      end else begin
        // pop the top, fetch the entry below it
        count_next = count_dec;
        mem_re     = 1'b1;
        state_next = S_SCAN;
      end
    end else if (state == S_SCAN) begin
      priority if ($signed(mem_rdata) == key) begin
        top_next   = $signed(mem_rdata);
        res_next   = '{$signed(mem_rdata), spum_pkg::DEPTH_W'(count), 1'b0,
                       spum_pkg::ST_OK};
        state_next = S_HOLD;
      end else if (count == CW'(1)) begin
        count_next = '0;
        res_next   = '{spum_pkg::EMPTY_TOP, spum_pkg::DEPTH_W'(0), 1'b1,
                       spum_pkg::ST_NOT_FOUND};
        state_next = S_HOLD;
      end else begin
        count_next = count_dec;
        mem_re     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    key <= key_next;
    res <= res_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> count != CW'(0))
    else $error("scan with empty stack");

  a_hold_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD |-> (res.is_empty == (count == CW'(0))))
    else $error("empty flag disagrees with fill count");

  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    acc && in_data.kind == spum_pkg::KIND_PUSH && count < CW'(DEPTH)
      |=> count == $past(count) + CW'(1))
    else $error("push did not grow the stack");

  a_scan_read: assert property (@(posedge clk) disable iff (rst)
    state_next == S_SCAN && !rst |-> mem_re)
    else $error("scan entered without a read");
`endif

endmodule

// File: dv/tb_stack_pop_until_match.sv
module tb_stack_pop_until_match;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH = spum_pkg::DEPTH_DEF;
  localparam int RAND_OPS    = 1950;     // random stack operations after the directed ones
  localparam int DRAIN_EVERY = 500;      // sender waits for an empty pipe this often
  localparam int HOLD_AT     = 700;      // beats sent before the long receiver hold-off
  localparam int HOLD_CYCLES = 90;
  localparam int QUIET_TAIL  = 200;      // last beats run with no idling at all
  localparam int CYCLE_LIMIT = 400000;

  // one queued stack operation; drain makes the sender wait for every result first
  typedef struct packed {
    logic          drain;
    spum_pkg::in_t beat;
  } pend_t;

  logic           clk;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  spum_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  spum_pkg::out_t out_data;

  stack_pop_until_match #(
    .DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  pend_t                              op_q[$];               // operations not yet offered
  spum_pkg::out_t                     predicted_state_q[$];  // stack state reports still owed
  logic signed [spum_pkg::WORD_W-1:0] gen_image[$];          // stack as the generator sees it
  bit                                 drain_next;

  // predictor copy of the stack
  logic signed [spum_pkg::WORD_W-1:0] shadow_stack[STACK_DEPTH];
  int                                 shadow_fill = 0;

  int sent_cnt  = 0;
  int recv_cnt  = 0;
  int beat_total = 0;
  int err_cnt   = 0;
  int gap_left  = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cyc_cnt   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // push or remove-until on the shadow stack, returning the state the block must report
  function automatic spum_pkg::out_t apply_stack_op(input spum_pkg::in_t op);
    spum_pkg::out_t rpt;
    logic [1:0]     st;
    st = spum_pkg::ST_OK;
    if (op.kind == spum_pkg::KIND_PUSH) begin
      if (shadow_fill < STACK_DEPTH) begin
        shadow_stack[shadow_fill] = op.value;
        shadow_fill++;
      end else begin
        st = spum_pkg::ST_FULL;   // value dropped, stack unchanged
      end
    end else begin
      // pop until the top matches; an empty stack or a miss leaves nothing
      while (shadow_fill > 0 && shadow_stack[shadow_fill-1] != op.value)
        shadow_fill--;
      if (shadow_fill == 0) st = spum_pkg::ST_NOT_FOUND;
    end
    rpt.top_value = (shadow_fill == 0) ? spum_pkg::EMPTY_TOP : shadow_stack[shadow_fill-1];
    rpt.depth     = spum_pkg::DEPTH_W'(shadow_fill);
    rpt.is_empty  = (shadow_fill == 0);
    rpt.status    = st;
    return rpt;
  endfunction

  // append one operation and track what the stack will hold, so pops can aim at real entries
  task automatic queue_op(input logic kind, input logic signed [spum_pkg::WORD_W-1:0] val);
    pend_t p;
    p.drain      = drain_next;
    p.beat.kind  = kind;
    p.beat.value = val;
    drain_next   = 1'b0;
    op_q.push_back(p);
    if (kind == spum_pkg::KIND_PUSH) begin
      if (gen_image.size() < STACK_DEPTH) gen_image.push_back(val);
    end else begin
      while (gen_image.size() > 0 && gen_image[$] != val) void'(gen_image.pop_back());
    end
  endtask

  // words biased toward extremes, the empty marker and small repeats
  function automatic logic signed [spum_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return spum_pkg::EMPTY_TOP;
      1:       return '0;
      2:       return '1;
      3:       return 32'sh7fff_ffff;
      4:       return 32'sh8000_0000;
      5, 6, 7: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // stimulus, reset and end of run
  initial begin
    int n;
    // directed: remove-until on an empty stack
    queue_op(spum_pkg::KIND_POP, 32'sd5);
    // fill with the extremes and the empty marker among the entries
    queue_op(spum_pkg::KIND_PUSH, 32'sh7fff_ffff);
    queue_op(spum_pkg::KIND_PUSH, 32'sh8000_0000);
    queue_op(spum_pkg::KIND_PUSH, spum_pkg::EMPTY_TOP);
    for (int i = 0; i < STACK_DEPTH - 3; i++) queue_op(spum_pkg::KIND_PUSH, i);
    // push when full is dropped
    queue_op(spum_pkg::KIND_PUSH, 32'sd99);
    // remove-until an entry deep down, a stored -1000 must not look empty
    queue_op(spum_pkg::KIND_POP, spum_pkg::EMPTY_TOP);
    // remove-until with the value already on top pops nothing
    queue_op(spum_pkg::KIND_POP, spum_pkg::EMPTY_TOP);
    // miss empties the stack
    queue_op(spum_pkg::KIND_POP, 32'sd12345);
    queue_op(spum_pkg::KIND_PUSH, '1);
    queue_op(spum_pkg::KIND_POP, '1);
    queue_op(spum_pkg::KIND_POP, '0);

    n = op_q.size();
    while (op_q.size() < n + RAND_OPS) begin
      if ((op_q.size() - n) % DRAIN_EVERY < 6 && (op_q.size() - n) / DRAIN_EVERY * DRAIN_EVERY
          + DRAIN_EVERY > op_q.size() - n && !drain_next && (op_q.size() - n) % DRAIN_EVERY == 0)
        drain_next = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(1, 6)) queue_op(spum_pkg::KIND_PUSH, pick_word());
        end
        5, 6, 7: begin
          // remove-until an entry that is on the stack, at a random height
          if (gen_image.size() > 0)
            queue_op(spum_pkg::KIND_POP, gen_image[$urandom_range(0, gen_image.size() - 1)]);
          else
            queue_op(spum_pkg::KIND_POP, pick_word());
        end
        8: queue_op(spum_pkg::KIND_POP, pick_word());
        default: begin
          // run into the full case
          while (gen_image.size() < STACK_DEPTH) queue_op(spum_pkg::KIND_PUSH, pick_word());
          repeat ($urandom_range(1, 2)) queue_op(spum_pkg::KIND_PUSH, pick_word());
        end
      endcase
    end
    beat_total = op_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sample between edges so the clocked processes have settled
    do @(negedge clk);
    while (rst || op_q.size() != 0 || in_valid || sent_cnt != recv_cnt);
    // give stray result beats time to show
    repeat (STACK_DEPTH + 8) @(posedge clk);
    if (predicted_state_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_state_q.size()));
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // driver: offers queued operations, predicts on every accepted beat
  always @(posedge clk) begin
    pend_t nxt;
    bit    quiet;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      sent_cnt <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_state_q.push_back(apply_stack_op(in_data));
        sent_cnt <= sent_cnt + 1;
      end
      // a new beat may go out only once the current one is gone
      if (!in_valid || in_ready) begin
        quiet = (sent_cnt >= beat_total - QUIET_TAIL) || ((sent_cnt / 150) % 3 == 1);
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (op_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (op_q[0].drain && (sent_cnt + int'(in_valid) != recv_cnt)) begin
          // pause until every owed result is back
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          nxt = op_q.pop_front();
          in_data  <= nxt.beat;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // long receiver hold-off, counted here, so the block backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks every accepted result beat against the oldest prediction
  always @(posedge clk) begin
    spum_pkg::out_t want;
    bit             quiet;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      recv_cnt   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        recv_cnt <= recv_cnt + 1;
        if (predicted_state_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing expected: %p",
                                    recv_cnt, out_data));
        end else begin
          want = predicted_state_q.pop_front();
          if (out_data.top_value !== want.top_value)
            report_mismatch($sformatf("beat %0d top_value %0d, want %0d",
                                      recv_cnt, out_data.top_value, want.top_value));
          if (out_data.depth !== want.depth)
            report_mismatch($sformatf("beat %0d depth %0d, want %0d",
                                      recv_cnt, out_data.depth, want.depth));
          if (out_data.is_empty !== want.is_empty)
            report_mismatch($sformatf("beat %0d is_empty %0b, want %0b",
                                      recv_cnt, out_data.is_empty, want.is_empty));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("beat %0d status %0d, want %0d",
                                      recv_cnt, out_data.status, want.status));
        end
      end
      quiet = (recv_cnt >= beat_total - QUIET_TAIL) || ((recv_cnt / 170) % 3 == 2);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 2);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
